// ===== design/ile_pkg.sv =====
// Package for the indexed list engine: field widths, operation codes, sizing
// constants and the control word that the top level broadcasts to every cell.
// Depends on nothing; every other file of the block uses it.
package ile_pkg;

   localparam int unsigned DEF_CAPACITY = 64;
   localparam int unsigned GROUP_SIZE   = 32;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned FUNC_W       = 3;
   localparam int unsigned POS_W        = 7;
   localparam int unsigned LEN_W        = 7;

   localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ      = 3'd0,
      FUNC_INS_FRONT = 3'd1,
      FUNC_INS_BACK  = 3'd2,
      FUNC_INS_AT    = 3'd3,
      FUNC_DELETE    = 3'd4
   } func_type;

   typedef struct packed {
      logic              ins;
      logic              del;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== design/ile_req_if.sv =====
// Request channel of the indexed list engine: valid/ready handshake plus the
// operation code, position and value of one word. Depends on ile_pkg.
interface ile_req_if;
   logic                       valid;
   logic                       ready;
   logic [ile_pkg::FUNC_W-1:0] func;
   logic [ile_pkg::POS_W-1:0]  position;
   logic signed [ile_pkg::DATA_W-1:0] value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink   (input valid, input func, input position, input value, output ready);
endinterface

// ===== design/ile_rsp_if.sv =====
// Response channel of the indexed list engine: valid/ready handshake plus the
// read value, found and accepted flags and the list length. Depends on ile_pkg.
interface ile_rsp_if;
   logic                       valid;
   logic                       ready;
   logic signed [ile_pkg::DATA_W-1:0] read_value;
   logic                       found;
   logic                       accepted;
   logic [ile_pkg::LEN_W-1:0]  length;

   modport source (output valid, output read_value, output found, output accepted,
                   output length, input ready);
   modport sink   (input valid, input read_value, input found, input accepted,
                   input length, output ready);
endinterface

// ===== design/ile_cell.sv =====
// One list cell: holds a single entry and takes the new value or its
// left neighbor on an insert, right neighbor on a delete. Depends on ile_pkg.
module ile_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned PW    = 7
) (
   input  logic                          clock,
   input  ile_pkg::cell_ctrl_type        ctrl,
   input  logic [PW-1:0]                 pos,
   input  logic [ile_pkg::DATA_W-1:0]    left_data,
   input  logic [ile_pkg::DATA_W-1:0]    right_data,
   output logic [ile_pkg::DATA_W-1:0]    entry,
   output logic [ile_pkg::DATA_W-1:0]    hit_data
);
   import ile_pkg::*;

   localparam logic [PW-1:0] MyIndex = PW'(INDEX);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (pos == MyIndex) begin
            entry_in = ctrl.value;
         end else if (MyIndex > pos) begin
            entry_in = left_data;
         end
      end else if (ctrl.del && (MyIndex >= pos)) begin
         entry_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   // Only the addressed cell puts its entry on the gather bus.
   assign hit_data = (pos == MyIndex) ? entry_ff : '0;

endmodule

// ===== design/indexed_list_engine.sv =====
// The request word is registered in the first stage, then in the output register.
// Throughput: one word per cycle while the response side is ready; the cells
// from the addressed position on shift in the cycle an insert or delete is accepted.
// The read path is a registered two-level OR gather over groups of cells.
// Reset clears the length and the valid flags of both pipeline stages;
// entries hold no reset value and are only read below the current length.
module indexed_list_engine #(
   parameter int unsigned CAPACITY = ile_pkg::DEF_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   ile_req_if.sink   req_chan,
   ile_rsp_if.source rsp_chan
);
   import ile_pkg::*;

   localparam int unsigned CntW      = $clog2(CAPACITY + 1);
   localparam int unsigned PosW      = (CntW > POS_W) ? CntW : POS_W;
   localparam int unsigned NumGroups = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   // List length and first stage.
   logic [CntW-1:0]   count_ff, count_in;
   logic              a_valid_ff, a_valid_in;
   logic              a_read_ff, a_read_in;
   logic              a_found_ff, a_found_in;
   logic              a_acc_ff, a_acc_in;
   logic [LEN_W-1:0]  a_len_ff, a_len_in;
   logic [DATA_W-1:0] part_ff [NumGroups];
   logic [DATA_W-1:0] part_in [NumGroups];

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_acc_ff, rsp_acc_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic              take_req;
   logic              a_advance;
   logic              stage_ready;
   logic [PosW-1:0]   pos_ext;
   logic [PosW-1:0]   cnt_ext;
   logic [PosW-1:0]   ins_pos;
   logic [PosW-1:0]   cell_pos;
   logic              want_ins;
   logic              want_del;
   logic              is_read;
   logic              list_full;
   logic              do_ins;
   logic              do_del;
   logic [DATA_W-1:0] gather;
   cell_ctrl_type     cell_ctrl;

   logic [DATA_W-1:0] entry [CAPACITY];
   logic [DATA_W-1:0] hit   [CAPACITY];

   assign a_advance   = !rsp_valid_ff || rsp_chan.ready;
   assign stage_ready = !a_valid_ff || a_advance;
   assign take_req    = req_chan.valid && stage_ready;
   assign req_chan.ready = stage_ready;

   assign pos_ext   = PosW'(req_chan.position);
   assign cnt_ext   = PosW'(count_ff);
   assign list_full = (count_ff == CntW'(CAPACITY));

   always_comb begin
      want_ins = 1'b0;
      want_del = 1'b0;
      is_read  = 1'b0;
      ins_pos  = '0;
      case (func_type'(req_chan.func))
         FUNC_READ: begin
            is_read = 1'b1;
         end
         FUNC_INS_FRONT: begin
            want_ins = 1'b1;
            ins_pos  = '0;
         end
         FUNC_INS_BACK: begin
            want_ins = 1'b1;
            ins_pos  = cnt_ext;
         end
         FUNC_INS_AT: begin
            want_ins = 1'b1;
            ins_pos  = pos_ext;
         end
         FUNC_DELETE: begin
            want_del = 1'b1;
         end
         default: begin
            want_ins = 1'b0;
         end
      endcase
   end

   assign do_ins   = take_req && want_ins && !list_full && (ins_pos <= cnt_ext);
   assign do_del   = take_req && want_del && (pos_ext < cnt_ext);
   assign cell_pos = want_ins ? ins_pos : pos_ext;

   assign cell_ctrl.ins   = do_ins;
   assign cell_ctrl.del   = do_del;
   assign cell_ctrl.value = req_chan.value;

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CntW'(1);
      end else if (do_del) begin
         count_in = count_ff - CntW'(1);
      end
   end

   genvar k;
   generate
      for (k = 0; k < CAPACITY; k++) begin : g_cell
         logic [DATA_W-1:0] left_data;
         logic [DATA_W-1:0] right_data;
         if (k == 0) begin : g_first
            assign left_data = req_chan.value;
         end else begin : g_mid_left
            assign left_data = entry[k-1];
         end
         if (k == CAPACITY - 1) begin : g_last
            assign right_data = entry[k];
         end else begin : g_mid_right
            assign right_data = entry[k+1];
         end
         ile_cell #(
            .INDEX (k),
            .PW    (PosW)
         ) u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .pos        (cell_pos),
            .left_data  (left_data),
            .right_data (right_data),
            .entry      (entry[k]),
            .hit_data   (hit[k])
         );
      end
   endgenerate

   // First gather level: OR the addressed cell's entry within each group.
   genvar g;
   generate
      for (g = 0; g < NumGroups; g++) begin : g_group
         always_comb begin
            part_in[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
               if (g * GROUP_SIZE + j < CAPACITY) begin
                  part_in[g] = part_in[g] | hit[g * GROUP_SIZE + j];
               end
            end
         end
      end
   endgenerate

   always_comb begin
      a_valid_in = a_valid_ff;
      a_read_in  = a_read_ff;
      a_found_in = a_found_ff;
      a_acc_in   = a_acc_ff;
      a_len_in   = a_len_ff;
      if (stage_ready) begin
         a_valid_in = take_req;
         a_read_in  = is_read;
         a_found_in = is_read && (pos_ext < cnt_ext);
         a_acc_in   = do_ins || do_del;
         a_len_in   = LEN_W'(count_in);
      end
   end

   // Second gather level across the group registers.
   always_comb begin
      gather = '0;
      for (int n = 0; n < NumGroups; n++) begin
         gather = gather | part_ff[n];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_len_in   = rsp_len_ff;
      if (a_advance) begin
         rsp_valid_in = a_valid_ff;
         rsp_value_in = a_read_ff ? (a_found_ff ? gather : MISS_VALUE) : '0;
         rsp_found_in = a_found_ff;
         rsp_acc_in   = a_acc_ff;
         rsp_len_in   = a_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_read_ff    <= a_read_in;
      a_found_ff   <= a_found_in;
      a_acc_ff     <= a_acc_in;
      a_len_ff     <= a_len_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_len_ff   <= rsp_len_in;
      if (stage_ready) begin
         for (int n = 0; n < NumGroups; n++) begin
            part_ff[n] <= part_in[n];
         end
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.accepted   = rsp_acc_ff;
   assign rsp_chan.length     = rsp_len_ff;

endmodule

// ===== design/ile_checker.sv =====
// Port-level checks for the indexed list engine, bound to its top level.
// Depends on ile_pkg and on the channel signals of indexed_list_engine.
module ile_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ile_pkg::DATA_W-1:0]   rsp_read_value,
   input logic                         rsp_accepted,
   input logic [ile_pkg::LEN_W-1:0]    rsp_length
);
   import ile_pkg::*;

   logic [2:0]       pending_ff, pending_in;
   logic [LEN_W-1:0] last_len_ff, last_len_in;
   logic             have_len_ff, have_len_in;
   logic             req_take;
   logic             rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in  = pending_ff + {2'b00, req_take} - {2'b00, rsp_take};
      last_len_in = rsp_take ? rsp_length : last_len_ff;
      have_len_in = have_len_ff || rsp_take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         have_len_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         have_len_ff <= have_len_in;
      end
   end

   always_ff @(posedge clock) begin
      last_len_ff <= last_len_in;
   end

   // A stalled response word keeps its read value and length.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_length))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Every response must answer a request word that was taken earlier.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without an outstanding request");

   // A word that did not change the list reports the previous length.
   a_len_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_accepted && have_len_ff |-> rsp_length == last_len_ff)
      else $error("length changed without an accepted update");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_accepted   (rsp_chan.accepted),
   .rsp_length     (rsp_chan.length)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for indexed_list_engine: random and directed list operations, each result
// checked against a built-in list predictor. Depends on ile_pkg, ile_req_if and ile_rsp_if.
module testbench;
   import ile_pkg::*;

   localparam int unsigned LIST_CAP = DEF_CAPACITY;
   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned LONG_HOLD = 120;

   // Function codes that the block must treat as no-ops.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic                     found;
      logic                     accepted;
      logic [LEN_W-1:0]         length;
   } list_result_type;

   logic clock = 1'b0;
   logic reset;

   ile_req_if req_chan ();
   ile_rsp_if rsp_chan ();

   indexed_list_engine #(.CAPACITY(LIST_CAP)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the list contents and length.
   logic signed [DATA_W-1:0] list_store [LIST_CAP];
   int unsigned list_len;

   list_result_type pending_results [$];
   int unsigned     mismatch_count;
   bit              no_idle;
   bit              hold_rsp;

   function automatic int unsigned idle_cycles();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return -32'sd1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic list_insert(input int unsigned at,
                                        input logic signed [DATA_W-1:0] val);
      if (list_len >= LIST_CAP || at > list_len) return 1'b0;
      for (int unsigned k = list_len; k > at; k--) list_store[k] = list_store[k-1];
      list_store[at] = val;
      list_len++;
      return 1'b1;
   endfunction

   function automatic logic list_delete(input int unsigned at);
      if (at >= list_len) return 1'b0;
      for (int unsigned k = at; k + 1 < list_len; k++) list_store[k] = list_store[k+1];
      list_len--;
      return 1'b1;
   endfunction

   // Applies one request to the shadow list and returns the response it must produce.
   function automatic list_result_type apply_list_request(input logic [FUNC_W-1:0] fn,
                                                          input logic [POS_W-1:0] pos,
                                                          input logic signed [DATA_W-1:0] val);
      list_result_type res;
      res = '0;
      case (fn)
         FUNC_READ: begin
            if (pos < list_len) begin
               res.read_value = list_store[pos];
               res.found = 1'b1;
            end else begin
               res.read_value = MISS_VALUE;
            end
         end
         FUNC_INS_FRONT: res.accepted = list_insert(0, val);
         FUNC_INS_BACK:  res.accepted = list_insert(list_len, val);
         FUNC_INS_AT:    res.accepted = list_insert(pos, val);
         FUNC_DELETE:    res.accepted = list_delete(pos);
         default: ;
      endcase
      res.length = list_len[LEN_W-1:0];
      return res;
   endfunction

   // Offers one word, waits until it is taken, then unless no_idle idles for a random gap.
   task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
      int unsigned gap;
      req_chan.valid    <= 1'b1;
      req_chan.func     <= fn;
      req_chan.position <= pos;
      req_chan.value    <= val;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(apply_list_request(fn, pos, val));
      gap = no_idle ? 0 : idle_cycles();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Picks an operation with the given share of inserts; positions mostly lie in 0..list_len.
   task automatic send_random_request(input int unsigned ins_pct);
      logic [FUNC_W-1:0] fn;
      logic [POS_W-1:0]  pos;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      if (pick < ins_pct) begin
         case ($urandom_range(0, 2))
            0: fn = FUNC_INS_FRONT;
            1: fn = FUNC_INS_BACK;
            default: fn = FUNC_INS_AT;
         endcase
      end else if (pick < ins_pct + (100 - ins_pct) / 2) begin
         fn = FUNC_DELETE;
      end else if (pick < 97) begin
         fn = FUNC_READ;
      end else begin
         case ($urandom_range(0, 2))
            0: fn = FUNC_SPARE_5;
            1: fn = FUNC_SPARE_6;
            default: fn = FUNC_SPARE_7;
         endcase
      end
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 127));
      else pos = POS_W'($urandom_range(0, list_len));
      send_request(fn, pos, random_word());
   endtask

   task automatic test_empty_list();
      send_request(FUNC_READ, 0, $urandom);
      send_request(FUNC_READ, 127, $urandom);
      send_request(FUNC_DELETE, 0, $urandom);
      send_request(FUNC_INS_AT, 1, $urandom);
      send_request(FUNC_SPARE_5, 0, $urandom);
      send_request(FUNC_SPARE_6, 127, $urandom);
      send_request(FUNC_SPARE_7, 42, $urandom);
      send_request(FUNC_INS_AT, 0, 32'sd1);
      send_request(FUNC_INS_FRONT, 0, WORD_MIN);
      send_request(FUNC_INS_BACK, 127, WORD_MAX);
      send_request(FUNC_INS_AT, 3, -32'sd1);
      send_request(FUNC_INS_AT, 1, '0);
      for (int i = 0; i <= 5; i++) send_request(FUNC_READ, POS_W'(i), $urandom);
      send_request(FUNC_DELETE, 5, $urandom);
      send_request(FUNC_DELETE, 127, $urandom);
      send_request(FUNC_DELETE, 2, $urandom);
      send_request(FUNC_DELETE, 0, $urandom);
      send_request(FUNC_DELETE, 2, $urandom);
      send_request(FUNC_SPARE_7, 0, $urandom);
   endtask

   task automatic test_full_list();
      while (list_len < LIST_CAP) begin
         case ($urandom_range(0, 2))
            0: send_request(FUNC_INS_FRONT, POS_W'($urandom), random_word());
            1: send_request(FUNC_INS_BACK, POS_W'($urandom), random_word());
            default: send_request(FUNC_INS_AT, POS_W'($urandom_range(0, list_len)),
                                  random_word());
         endcase
      end
      // Every insert on a full list is refused, including one at the end position.
      send_request(FUNC_INS_FRONT, 0, $urandom);
      send_request(FUNC_INS_BACK, 0, $urandom);
      send_request(FUNC_INS_AT, 0, $urandom);
      send_request(FUNC_INS_AT, POS_W'(LIST_CAP), $urandom);
      send_request(FUNC_READ, POS_W'(LIST_CAP - 1), $urandom);
      send_request(FUNC_READ, POS_W'(LIST_CAP), $urandom);
      send_request(FUNC_DELETE, POS_W'(LIST_CAP), $urandom);
      send_request(FUNC_SPARE_6, 3, $urandom);
      send_request(FUNC_DELETE, POS_W'(LIST_CAP - 1), $urandom);
      send_request(FUNC_INS_AT, POS_W'(LIST_CAP - 1), WORD_MAX);
      send_request(FUNC_READ, POS_W'(LIST_CAP - 1), $urandom);
   endtask

   task automatic test_random_ops();
      for (int phase = 0; phase < 9; phase++) begin
         no_idle = (phase % 3 == 2);
         for (int i = 0; i < 95; i++) send_random_request(phase % 2 == 0 ? 80 : 20);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_back_pressure();
      no_idle = 1'b1;
      for (int round = 0; round < 2; round++) begin
         hold_rsp = 1'b1;
         for (int i = 0; i < 60; i++) send_random_request(50);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_drain_to_empty();
      while (list_len > 0) begin
         if ($urandom_range(0, 3) == 0) begin
            send_request(FUNC_READ, POS_W'($urandom_range(0, list_len)), $urandom);
         end else begin
            send_request(FUNC_DELETE, POS_W'($urandom_range(0, list_len - 1)), $urandom);
         end
      end
      send_request(FUNC_READ, 0, $urandom);
      send_request(FUNC_DELETE, 0, $urandom);
   endtask

   // Response side: random stalls, plus one long hold each time a test asks for it.
   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = no_idle ? 0 : idle_cycles();
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: response word with nothing outstanding, got %0h %0b %0b %0d",
                     $time, rsp_chan.read_value, rsp_chan.found, rsp_chan.accepted,
                     rsp_chan.length);
         end else begin
            want = pending_results.pop_front();
            report_field("read_value", want.read_value, rsp_chan.read_value);
            report_field("found", want.found, rsp_chan.found);
            report_field("accepted", want.accepted, rsp_chan.accepted);
            report_field("length", want.length, rsp_chan.length);
         end
      end
   end

   // Ends the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      int unsigned quiet_cycles;
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_READ;
      req_chan.position = '0;
      req_chan.value = '0;
      list_len = 0;
      mismatch_count = 0;
      no_idle = 1'b0;
      hold_rsp = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_full_list();
      test_random_ops();
      test_back_pressure();
      test_drain_to_empty();
      req_chan.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
